/* src/sfe_pkg.sv */
// Shared types, constants and CRC helper for the SUMD frame encoder.
`timescale 1ns / 1ps

package sfe_pkg;

    // Frame and channel limits.
    localparam int MAX_CHANNELS    = 16;
    localparam int CHAN_FULL_SCALE = 10000;
    localparam int COUNT_W         = 5;
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(8);

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_CHANNEL_COUNT = 1'b0;

    // Frame constants.
    localparam logic [15:0] SUMD_POLY   = 16'h1021;
    localparam logic [7:0]  SUMD_VENDOR = 8'hA8;
    localparam logic [7:0]  SUMD_STATUS = 8'h01;
    localparam int          SUMD_SCALE  = 3200;
    localparam logic [15:0] SUMD_CENTER = 16'd12000;

    // Channel value and scaling datapath widths.
    localparam int VALUE_W = 15;
    localparam int MAG_W   = VALUE_W;
    localparam int FS_W    = 14;
    localparam int NUM_W   = MAG_W + $clog2(SUMD_SCALE + 1);
    localparam int RECIP_SHIFT = NUM_W + FS_W;
    localparam int RECIP_W = RECIP_SHIFT - $clog2(CHAN_FULL_SCALE) + 1;
    localparam longint unsigned RECIP_FULL =
        ((longint'(1) << RECIP_SHIFT) + longint'(CHAN_FULL_SCALE) - 1) /
        longint'(CHAN_FULL_SCALE);
    localparam logic [RECIP_W-1:0] RECIP_M = RECIP_FULL[RECIP_W-1:0];
    localparam int PROD_W = NUM_W + RECIP_W;

    // Scaled channel word passed from the scaler to the serializer.
    typedef struct packed {
        logic        valid;
        logic [15:0] word;
    } chan_beat_t;

    // Byte position within the work for one channel.
    typedef enum logic [6:0] {
        ST_VENDOR  = 7'b0000001,
        ST_STATUS  = 7'b0000010,
        ST_COUNT   = 7'b0000100,
        ST_CHAN_HI = 7'b0001000,
        ST_CHAN_LO = 7'b0010000,
        ST_CRC_HI  = 7'b0100000,
        ST_CRC_LO  = 7'b1000000
    } step_t;

    // CRC-16, MSB first, one byte.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ SUMD_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // Channel count as used in the frame: zero counts as one, large values saturate.
    function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] count);
        logic [COUNT_W-1:0] r;
        r = count;
        if (count == '0) begin
            r = COUNT_W'(1);
        end else if (count > COUNT_W'(MAX_CHANNELS)) begin
            r = COUNT_W'(MAX_CHANNELS);
        end
        return r;
    endfunction

endpackage

/* src/sfe_scaler.sv */
// Two-stage scaler from a signed channel value to the 16-bit SUMD channel word.
`timescale 1ns / 1ps

module sfe_scaler
    import sfe_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [VALUE_W-1:0] s_channel_value,
    output chan_beat_t                chan_out,
    input  logic                      chan_ready
);

    logic               in_valid_reg, in_valid_next;
    logic               in_neg_reg;
    logic [NUM_W-1:0]   in_num_reg;
    logic               q_valid_reg, q_valid_next;
    logic [15:0]        word_reg;

    logic               in_take, q_take;
    logic               neg;
    logic [MAG_W-1:0]   mag;
    logic [NUM_W-1:0]   num;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  quot;
    logic [15:0]        q16;
    logic [15:0]        word;

    assign q_take  = !q_valid_reg || chan_ready;
    assign in_take = !in_valid_reg || q_take;
    assign s_ready = in_take;

    // Magnitude times the scale; the quotient is taken on the magnitude so that
    // negative values truncate toward zero.
    assign neg = s_channel_value[VALUE_W-1];
    assign mag = neg ? (~MAG_W'(s_channel_value) + MAG_W'(1)) : MAG_W'(s_channel_value);
    assign num = NUM_W'(mag) * NUM_W'(SUMD_SCALE);

    // Division by the full scale as a multiply by its rounded-up reciprocal,
    // exact for every numerator this stage can hold.
    assign prod = PROD_W'(in_num_reg) * PROD_W'(RECIP_M);
    assign quot = prod >> RECIP_SHIFT;
    assign q16  = quot[15:0];
    assign word = in_neg_reg ? (SUMD_CENTER - q16) : (SUMD_CENTER + q16);

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_take) begin
            in_valid_next = s_valid;
        end
        q_valid_next = q_valid_reg;
        if (q_take) begin
            q_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            q_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            q_valid_reg  <= q_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take && s_valid) begin
            in_neg_reg <= neg;
            in_num_reg <= num;
        end
        if (q_take && in_valid_reg) begin
            word_reg <= word;
        end
    end

    assign chan_out.valid = q_valid_reg;
    assign chan_out.word  = word_reg;

endmodule

/* src/sfe_serializer.sv */
// Frame sequencer: emits header, channel and CRC bytes one beat at a time.
`timescale 1ns / 1ps

module sfe_serializer
    import sfe_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [COUNT_W-1:0] channel_count,
    input  chan_beat_t         chan_in,
    output logic               chan_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_frame_end
);

    logic               job_valid_reg, job_valid_next;
    step_t              job_step_reg, job_step_next;
    logic               job_end_reg, job_end_next;
    logic [15:0]        job_chan_reg, job_chan_next;
    logic [COUNT_W-1:0] chan_index_reg, chan_index_next;
    logic [15:0]        crc_reg, crc_next;
    logic               m_valid_reg, m_valid_next;
    logic [7:0]         m_byte_reg, m_byte_next;
    logic               m_end_reg, m_end_next;

    logic               out_free, emit, last, job_take;
    logic [COUNT_W-1:0] eff, idx_inc;
    logic               load_end;
    logic [7:0]         byte_sel;
    logic               end_sel;
    step_t              step_adv;
    logic [15:0]        crc_adv;

    assign eff      = eff_count(channel_count);
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = job_valid_reg && out_free;
    assign job_take = !job_valid_reg || (emit && last);
    assign chan_ready = job_take;

    assign idx_inc  = chan_index_reg + COUNT_W'(1);
    assign load_end = (idx_inc == '0) || (idx_inc >= eff);

    // Byte, CRC update and next position for the current step.
    always_comb begin
        byte_sel = 8'h00;
        end_sel  = 1'b0;
        step_adv = job_step_reg;
        crc_adv  = crc_reg;
        last     = 1'b0;
        unique case (job_step_reg)
            ST_VENDOR: begin
                byte_sel = SUMD_VENDOR;
                crc_adv  = crc_feed(16'h0000, SUMD_VENDOR);
                step_adv = ST_STATUS;
            end
            ST_STATUS: begin
                byte_sel = SUMD_STATUS;
                crc_adv  = crc_feed(crc_reg, SUMD_STATUS);
                step_adv = ST_COUNT;
            end
            ST_COUNT: begin
                byte_sel = 8'(eff);
                crc_adv  = crc_feed(crc_reg, 8'(eff));
                step_adv = ST_CHAN_HI;
            end
            ST_CHAN_HI: begin
                byte_sel = job_chan_reg[15:8];
                crc_adv  = crc_feed(crc_reg, job_chan_reg[15:8]);
                step_adv = ST_CHAN_LO;
            end
            ST_CHAN_LO: begin
                byte_sel = job_chan_reg[7:0];
                crc_adv  = crc_feed(crc_reg, job_chan_reg[7:0]);
                step_adv = ST_CRC_HI;
                last     = !job_end_reg;
            end
            ST_CRC_HI: begin
                byte_sel = crc_reg[15:8];
                step_adv = ST_CRC_LO;
            end
            ST_CRC_LO: begin
                byte_sel = crc_reg[7:0];
                end_sel  = 1'b1;
                crc_adv  = 16'h0000;
                last     = 1'b1;
            end
            default: begin
                byte_sel = 8'h00;
            end
        endcase
    end

    always_comb begin
        job_valid_next  = job_valid_reg;
        job_step_next   = job_step_reg;
        job_end_next    = job_end_reg;
        job_chan_next   = job_chan_reg;
        chan_index_next = chan_index_reg;
        crc_next        = crc_reg;
        m_valid_next    = m_valid_reg;
        m_byte_next     = m_byte_reg;
        m_end_next      = m_end_reg;

        if (emit) begin
            m_valid_next  = 1'b1;
            m_byte_next   = byte_sel;
            m_end_next    = end_sel;
            crc_next      = crc_adv;
            job_step_next = step_adv;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        // A new channel loads as soon as the previous one has sent its last byte.
        if (job_take) begin
            job_valid_next = chan_in.valid;
            if (chan_in.valid) begin
                job_step_next   = (chan_index_reg == '0) ? ST_VENDOR : ST_CHAN_HI;
                job_end_next    = load_end;
                job_chan_next   = chan_in.word;
                chan_index_next = load_end ? '0 : idx_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg  <= 1'b0;
            job_step_reg   <= ST_VENDOR;
            chan_index_reg <= '0;
            crc_reg        <= 16'h0000;
            m_valid_reg    <= 1'b0;
        end else begin
            job_valid_reg  <= job_valid_next;
            job_step_reg   <= job_step_next;
            chan_index_reg <= chan_index_next;
            crc_reg        <= crc_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_end_reg  <= job_end_next;
        job_chan_reg <= job_chan_next;
        m_byte_reg   <= m_byte_next;
        m_end_reg    <= m_end_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_out_byte  = m_byte_reg;
    assign m_frame_end = m_end_reg;

endmodule

/* src/sumd_frame_encoder_top.sv */
// Top level of the SUMD frame encoder: register port, scaler and byte serializer.
//
// Each beat on the s_ channel carries one signed channel value. The m_ channel
// carries the frame one byte per beat: header bytes 0xA8, 0x01 and the channel
// count before the first channel, the scaled channel word high byte first, and
// after the last channel of the frame the CRC-16 high and low bytes, the low
// byte marked by m_frame_end.
// The channel_count register sits at address 0 of the APB port; write it only
// while the block is idle.
// The first byte of a channel passes the scaler input and output registers, the
// serializer job register and the output byte register before m_valid rises.
// The output byte lane sends one byte per cycle while m_ready allows; a channel
// is 2 bytes, plus 3 header bytes before the first and 2 CRC bytes after the last.
// The scaler stages keep taking beats while earlier bytes are still sent.
// When the receiver stalls, the output byte holds and the pipeline fills up,
// after which s_ready drops. Reset empties the pipeline, starts a new frame
// and sets channel_count to 8.
`timescale 1ns / 1ps

module sumd_frame_encoder_top
    import sfe_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0]     pwdata,
    output logic [APB_DATA_W-1:0]     prdata,
    output logic                      pready,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [VALUE_W-1:0] s_channel_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [7:0]                m_out_byte,
    output logic                      m_frame_end
);

    logic [COUNT_W-1:0] count_reg, count_next;
    logic               reg_sel;
    logic               wr_en;
    chan_beat_t         chan_beat;
    logic               chan_ready;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_CHANNEL_COUNT);
    assign wr_en   = psel && penable && pwrite && pready && reg_sel;

    always_comb begin
        count_next = count_reg;
        if (wr_en) begin
            count_next = pwdata[COUNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= COUNT_RESET;
        end else begin
            count_reg <= count_next;
        end
    end

    assign prdata = reg_sel ? APB_DATA_W'(count_reg) : '0;

    sfe_scaler u_scaler (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_channel_value (s_channel_value),
        .chan_out        (chan_beat),
        .chan_ready      (chan_ready)
    );

    sfe_serializer u_serializer (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .channel_count (count_reg),
        .chan_in       (chan_beat),
        .chan_ready    (chan_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_frame_end   (m_frame_end)
    );

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the SUMD frame encoder: channel beats in, frame bytes out.
`timescale 1ns / 1ps

module tb_top;
    import sfe_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam logic [APB_ADDR_W-1:0] ADDR_CHANNEL_COUNT = APB_ADDR_W'(4 * REG_CHANNEL_COUNT);
    localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED = APB_ADDR_W'(4 * (REG_CHANNEL_COUNT + 1));

    typedef enum logic [1:0] {
        ROW_CHANNEL,
        ROW_REG_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [APB_ADDR_W-1:0] addr;
        logic [31:0]           data;
        logic [VALUE_W-1:0]    value;
        logic                  typed;
        logic [15:0]           word;
    } stim_row_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_byte_t;

    logic                      aclk            = 1'b0;
    logic                      aresetn         = 1'b0;
    logic                      psel            = 1'b0;
    logic                      penable         = 1'b0;
    logic                      pwrite          = 1'b0;
    logic [APB_ADDR_W-1:0]     paddr           = '0;
    logic [APB_DATA_W-1:0]     pwdata          = '0;
    logic [APB_DATA_W-1:0]     prdata;
    logic                      pready;
    logic                      s_valid         = 1'b0;
    logic                      s_ready;
    logic signed [VALUE_W-1:0] s_channel_value = '0;
    logic                      m_valid;
    logic                      m_ready         = 1'b0;
    logic [7:0]                m_out_byte;
    logic                      m_frame_end;

    // Predicted encoder state and the bytes still owed by the block.
    logic [COUNT_W-1:0] count_reg = COUNT_RESET;
    logic [4:0]         chan_pos  = '0;
    logic [15:0]        frame_crc = '0;
    frame_byte_t        frame_bytes_due[$];

    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int rx_hold_left = 0;
    int errors       = 0;
    int beats_sent   = 0;
    int bytes_seen   = 0;
    int frames_seen  = 0;

    // Directed beats: word is typed in where the scaled value is easy to read off.
    stim_row_t directed_rows [0:24] = '{
        '{ROW_CHANNEL,   ADDR_CHANNEL_COUNT, 32'd0, VALUE_W'(0),      1'b1, 16'h2EE0},
        '{ROW_CHANNEL,   ADDR_CHANNEL_COUNT, 32'd0, VALUE_W'(16383),  1'b1, 16'h435A},
        '{ROW_CHANNEL,   ADDR_CHANNEL_COUNT, 32'd0, VALUE_W'(-16384), 1'b1, 16'h1A66},
        '{ROW_CHANNEL,   ADDR_CHANNEL_COUNT, 32'd0, VALUE_W'(10000),  1'b1, 16'h3B60},
        '{ROW_CHANNEL,   ADDR_CHANNEL_COUNT, 32'd0, VALUE_W'(-10000), 1'b1, 16'h2260},
        '{ROW_CHANNEL,   ADDR_CHANNEL_COUNT, 32'd0, VALUE_W'(-1),     1'b1, 16'h2EE0},
        '{ROW_CHANNEL,   ADDR_CHANNEL_COUNT, 32'd0, VALUE_W'(-4),     1'b1, 16'h2EDF},
        '{ROW_CHANNEL,   ADDR_CHANNEL_COUNT, 32'd0, VALUE_W'(4),      1'b1, 16'h2EE1},
        '{ROW_REG_WRITE, ADDR_CHANNEL_COUNT, 32'd1, VALUE_W'(0),      1'b0, 16'h0000},
        '{ROW_CHANNEL,   ADDR_CHANNEL_COUNT, 32'd0, VALUE_W'(1),      1'b1, 16'h2EE0},
        '{ROW_CHANNEL,   ADDR_CHANNEL_COUNT, 32'd0, VALUE_W'(5000),   1'b1, 16'h3520},
        '{ROW_REG_WRITE, ADDR_CHANNEL_COUNT, 32'd0, VALUE_W'(0),      1'b0, 16'h0000},
        '{ROW_CHANNEL,   ADDR_CHANNEL_COUNT, 32'd0, VALUE_W'(-5000),  1'b1, 16'h28A0},
        '{ROW_REG_WRITE, ADDR_CHANNEL_COUNT, 32'd31, VALUE_W'(0),     1'b0, 16'h0000},
        '{ROW_CHANNEL,   ADDR_CHANNEL_COUNT, 32'd0, VALUE_W'(123),    1'b0, 16'h0000},
        '{ROW_CHANNEL,   ADDR_CHANNEL_COUNT, 32'd0, VALUE_W'(-7777),  1'b0, 16'h0000},
        '{ROW_CHANNEL,   ADDR_CHANNEL_COUNT, 32'd0, VALUE_W'(8191),   1'b0, 16'h0000},
        '{ROW_REG_WRITE, ADDR_UNMAPPED,      32'd3, VALUE_W'(0),      1'b0, 16'h0000},
        '{ROW_CHANNEL,   ADDR_CHANNEL_COUNT, 32'd0, VALUE_W'(2),      1'b0, 16'h0000},
        '{ROW_REG_WRITE, ADDR_CHANNEL_COUNT, 32'd2, VALUE_W'(0),      1'b0, 16'h0000},
        '{ROW_CHANNEL,   ADDR_CHANNEL_COUNT, 32'd0, VALUE_W'(-2),     1'b0, 16'h0000},
        '{ROW_REG_WRITE, ADDR_CHANNEL_COUNT, 32'hFFFF_FFE3, VALUE_W'(0), 1'b0, 16'h0000},
        '{ROW_CHANNEL,   ADDR_CHANNEL_COUNT, 32'd0, VALUE_W'(16383),  1'b1, 16'h435A},
        '{ROW_CHANNEL,   ADDR_CHANNEL_COUNT, 32'd0, VALUE_W'(-16384), 1'b1, 16'h1A66},
        '{ROW_CHANNEL,   ADDR_CHANNEL_COUNT, 32'd0, VALUE_W'(0),      1'b1, 16'h2EE0}
    };

    sumd_frame_encoder_top uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_channel_value (s_channel_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_frame_end     (m_frame_end)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc ^ {b, 8'h00};
        repeat (8) begin
            r = r[15] ? ({r[14:0], 1'b0} ^ SUMD_POLY) : {r[14:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [15:0] scale_channel(input logic [VALUE_W-1:0] raw);
        int v;
        int q;
        v = $signed(raw);
        // Kept in int so the division truncates toward zero on negative values.
        q = v * SUMD_SCALE / CHAN_FULL_SCALE;
        return 16'(q + int'(SUMD_CENTER));
    endfunction

    function automatic void push_frame_byte(input logic [7:0] b, input logic last,
                                            input bit feed);
        if (feed) begin
            frame_crc = crc16_update(frame_crc, b);
        end
        frame_bytes_due.push_back('{b, last});
    endfunction

    function automatic void encode_channel(input logic [VALUE_W-1:0] raw, input logic typed,
                                           input logic [15:0] typed_word);
        logic [COUNT_W-1:0] eff;
        logic [15:0]        word;
        eff = count_reg;
        if (count_reg == '0) begin
            eff = COUNT_W'(1);
        end else if (count_reg > MAX_CHANNELS) begin
            eff = COUNT_W'(MAX_CHANNELS);
        end
        if (chan_pos == '0) begin
            frame_crc = '0;
            push_frame_byte(SUMD_VENDOR, 1'b0, 1'b1);
            push_frame_byte(SUMD_STATUS, 1'b0, 1'b1);
            push_frame_byte(8'(eff), 1'b0, 1'b1);
        end
        word = typed ? typed_word : scale_channel(raw);
        push_frame_byte(word[15:8], 1'b0, 1'b1);
        push_frame_byte(word[7:0], 1'b0, 1'b1);
        chan_pos = chan_pos + 5'd1;
        // A count lowered below the current position closes the frame right here.
        if (chan_pos == '0 || chan_pos >= eff) begin
            push_frame_byte(frame_crc[15:8], 1'b0, 1'b0);
            push_frame_byte(frame_crc[7:0], 1'b1, 1'b0);
            chan_pos  = '0;
            frame_crc = '0;
        end
    endfunction

    function automatic logic [VALUE_W-1:0] random_channel();
        unique case ($urandom_range(7))
            0: return VALUE_W'(16383);
            1: return VALUE_W'(-16384);
            2: return VALUE_W'($signed($urandom_range(64)) - 32);
            default: return VALUE_W'($urandom_range(32767));
        endcase
    endfunction

    task automatic send_channel(input logic [VALUE_W-1:0] raw, input logic typed,
                                input logic [15:0] typed_word);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_channel_value <= raw;
        do @(posedge aclk); while (!s_ready);
        encode_channel(raw, typed, typed_word);
        beats_sent++;
    endtask

    // Stops offering beats and waits until every owed byte has come out.
    task automatic settle_frames();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (frame_bytes_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr[APB_ADDR_W-1:2] == REG_CHANNEL_COUNT) begin
            count_reg = data[COUNT_W-1:0];
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    always @(negedge aclk) begin
        if (rx_hold_left > 0) begin
            m_ready <= 1'b0;
            rx_hold_left = rx_hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        frame_byte_t due;
        if (aresetn && m_valid && m_ready) begin
            if (frame_bytes_due.size() == 0) begin
                $error("out_byte: no byte expected, got %02h (frame_end %b)",
                       m_out_byte, m_frame_end);
                errors++;
            end else begin
                due = frame_bytes_due.pop_front();
                bytes_seen++;
                if (due.last) begin
                    frames_seen++;
                end
                if (m_out_byte !== due.data) begin
                    $error("out_byte: expected %02h, got %02h", due.data, m_out_byte);
                    errors++;
                end
                if (m_frame_end !== due.last) begin
                    $error("frame_end: expected %b, got %b", due.last, m_frame_end);
                    errors++;
                end
            end
        end
    end

    initial begin
        #3_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        int phase;
        int k;
        int phase_beats [3];
        int phase_count [3];
        phase_beats = '{40, 40, 31};
        phase_count = '{MAX_CHANNELS, $urandom_range(31), $urandom_range(MAX_CHANNELS, 1)};
        tx_idle_pct = 10;
        rx_idle_pct = 75;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REG_WRITE) begin
                settle_frames();
                apb_write(directed_rows[i].addr, directed_rows[i].data);
            end else begin
                send_channel(directed_rows[i].value, directed_rows[i].typed,
                             directed_rows[i].word);
            end
        end

        for (phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 75 : 0;
            rx_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 10 : 0;
            settle_frames();
            apb_write(ADDR_CHANNEL_COUNT, 32'(phase_count[phase]));
            for (k = 0; k < phase_beats[phase]; k++) begin
                if (phase == 1 && k == 20) begin
                    settle_frames();
                end
                // The output holds off while beats keep coming, so the input must stall.
                if (phase == 2 && k == 10) begin
                    rx_hold_left = HOLD_CYCLES;
                end
                send_channel(random_channel(), 1'b0, 16'h0000);
            end
        end
        settle_frames();

        $display("Sent %0d channel beats; checked %0d bytes in %0d frames.",
                 beats_sent, bytes_seen, frames_seen);
        $display("Counts 0, 1, 2, 3, 8, 16, 31 and random, idle gaps, drains and a long hold.");
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/sfe_pkg.sv
src/sfe_scaler.sv
src/sfe_serializer.sv
src/sumd_frame_encoder_top.sv
sim/tb_top.sv
